[rtl/hit_pkg.sv]
package hit_pkg;

    localparam int MAX_MODELS_DEF  = 4;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int COEF_WIDTH_DEF  = 48;

    localparam int FRAC_SHIFT = 4;
    localparam int SAT_SHIFT  = 26;
    localparam int THR_WIDTH  = 16;
    localparam int NUM_WIDTH  = 3;

    localparam logic [0:0] CFG_THRESHOLD = 1'd0;
    localparam logic [0:0] CFG_MODELS    = 1'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TEST = 1'b1;

    // One-hot sequencer states.
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ROW   = 8'b0000_0010,
        ST_DIVX  = 8'b0000_0100,
        ST_DIVY  = 8'b0000_1000,
        ST_ERR   = 8'b0001_0000,
        ST_NEXT  = 8'b0010_0000,
        ST_DONE  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic keep;
        logic [1:0] first_model;
        logic [3:0] model_hits;
        logic degenerate;
    } t_result;

endpackage

[rtl/hit_divider.sv]
// Restoring divider: magnitude quotient of (num<<4)/den, one bit a cycle,
// saturated to 2^SAT_SHIFT; signed result.
module hit_divider #(
    parameter int W = 128
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [W-1:0]  i_num,
    input  logic signed [W-1:0]  i_den,
    output logic                 o_done,
    output logic signed [hit_pkg::SAT_SHIFT+1:0] o_quot
);
    import hit_pkg::*;

    localparam int QW = SAT_SHIFT + 2;
    localparam int RW = W + FRAC_SHIFT + 1;
    localparam int DW = RW + SAT_SHIFT;

    logic [RW-1:0]       r_rem, n_rem;
    logic [RW-1:0]       r_den, n_den;
    logic [QW-1:0]       r_q, n_q;
    logic [4:0]          r_bit, n_bit;
    logic                r_busy, n_busy;
    logic                r_neg, n_neg;
    logic                r_done, n_done;
    logic [DW-1:0]       w_trial;
    logic [RW-1:0]       w_anum, w_aden;

    assign w_anum = RW'(i_num[W-1] ? -i_num : i_num) << FRAC_SHIFT;
    assign w_aden = RW'(i_den[W-1] ? -i_den : i_den);
    // Shifted divisor needs SAT_SHIFT bits of headroom above the remainder.
    assign w_trial = DW'(r_den) << r_bit;

    always_comb begin
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        n_bit  = r_bit;
        n_busy = r_busy;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = w_anum;
            n_den  = w_aden;
            n_neg  = i_num[W-1] ^ i_den[W-1];
            n_q    = '0;
            n_bit  = 5'(SAT_SHIFT - 1);
            n_busy = 1'b1;
            if ((DW'(w_aden) << SAT_SHIFT) <= DW'(w_anum)) begin
                n_q    = QW'(1) << SAT_SHIFT;
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (r_busy) begin
            if (w_trial <= DW'(r_rem)) begin
                n_rem = r_rem - RW'(w_trial);
                n_q   = r_q | (QW'(1) << r_bit);
            end
            if (r_bit == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_bit <= n_bit;
        r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_bit == $past(r_bit) - 5'd1) || r_done)
        else $error("divider bit counter skipped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_q < (QW'(1) << SAT_SHIFT))
        else $error("divider quotient overflow");
endmodule

[rtl/homography_inlier_test.sv]
// Homography inlier test. Load beats (tuser command = 0) write one signed
// Q24.24 coefficient into a table of MAX_MODELS 3x3 matrices and give no
// result; loads beyond the table are dropped. Test beats (command = 1)
// map the reference point through each model in use, divide by the third
// row and keep the match when the squared distance to the target is below
// the squared threshold. Entries of the table must be written before a test
// reads them. One shared multiplier (coordinate x coefficient) forms the
// three row sums per model, then one restoring divider computes x and y
// (skipping the bit steps when the quotient saturates), and the ST_NEXT
// state steps to the next model; a model with a zero denominator skips the
// divides. A load leaves the block ready for the next beat. The block is
// not ready while a test is in progress. The verdict sits in an output
// register, so a waiting verdict does not block new beats; a finished test
// holds until that register is free.
// Configuration is written through its own channel: index 0 is the Q12.4
// distance threshold, index 1 the number of models.
module homography_inlier_test #(
    parameter int MAX_MODELS  = hit_pkg::MAX_MODELS_DEF,
    parameter int COORD_WIDTH = hit_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = hit_pkg::COEF_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: coef_index[5:0], coef_value[53:6], ref_x, ref_y, tgt_x, tgt_y,
    // zero pad up to whole bytes
    input  logic [((COEF_WIDTH+4*COORD_WIDTH+6+7)/8)*8-1:0] s_axis_tdata,
    // tuser: command
    input  logic        s_axis_tuser,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: keep, first_model[2:1], model_hits[6:3], degenerate[7]
    output logic [7:0]  m_axis_tdata
);
    import hit_pkg::*;

    localparam int DEPTH = MAX_MODELS * 9;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = (MAX_MODELS > 1) ? $clog2(MAX_MODELS) : 1;
    localparam int PW    = COORD_WIDTH + COEF_WIDTH + 1;
    localparam int SW    = PW + 6;
    localparam int CB    = 6;
    localparam int XB    = CB + COEF_WIDTH;

    logic signed [COEF_WIDTH-1:0] r_mem [DEPTH];

    logic [THR_WIDTH-1:0] r_thr;
    logic [NUM_WIDTH-1:0] r_num;
    t_state r_st, n_st;

    logic [COORD_WIDTH-1:0] r_rx, r_ry, r_tx, r_ty;
    logic [MW:0]  r_m;
    logic [3:0]   r_k;
    logic [AW-1:0] r_addr;
    logic signed [COEF_WIDTH-1:0] r_rd;
    logic signed [SW-1:0] r_acc, r_s0, r_s1, r_s2;
    logic signed [SAT_SHIFT+1:0] r_px;
    logic r_keep, r_deg;
    logic [1:0] r_first;
    logic [MAX_MODELS-1:0] r_hits;
    logic [MW:0] w_n;
    t_result r_res;
    logic r_ovalid;

    logic w_in_acc, w_div_start, w_div_done, w_out_free;
    logic [1:0] w_col, w_row;
    logic signed [SW-1:0] w_div_num;
    logic signed [SAT_SHIFT+1:0] w_quot;
    logic signed [SW-1:0] w_term;
    logic signed [SAT_SHIFT+2:0] w_dx, w_dy;
    logic [2*SAT_SHIFT+7:0] w_err;

    assign w_in_acc     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_st == ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    // Output register is free when empty or its beat leaves at this edge.
    assign w_out_free   = !r_ovalid || m_axis_tready;
    assign w_n = (int'(r_num) > MAX_MODELS) ? (MW+1)'(MAX_MODELS)
                                            : (MW+1)'(r_num);

    // Steps 1..9 walk the matrix row by row; steps 0 and 10 carry no term.
    always_comb begin
        unique case (r_k)
            4'd1:    begin w_col = 2'd0; w_row = 2'd0; end
            4'd2:    begin w_col = 2'd1; w_row = 2'd0; end
            4'd3:    begin w_col = 2'd2; w_row = 2'd0; end
            4'd4:    begin w_col = 2'd0; w_row = 2'd1; end
            4'd5:    begin w_col = 2'd1; w_row = 2'd1; end
            4'd6:    begin w_col = 2'd2; w_row = 2'd1; end
            4'd7:    begin w_col = 2'd0; w_row = 2'd2; end
            4'd8:    begin w_col = 2'd1; w_row = 2'd2; end
            4'd9:    begin w_col = 2'd2; w_row = 2'd2; end
            default: begin w_col = 2'd3; w_row = 2'd0; end
        endcase
    end

    // Shared multiplier: column 0 uses x, column 1 uses y, column 2 is shifted.
    always_comb begin
        unique case (w_col)
            2'd0:    w_term = SW'($signed({1'b0, r_rx}) * r_rd);
            2'd1:    w_term = SW'($signed({1'b0, r_ry}) * r_rd);
            default: w_term = SW'(r_rd) <<< FRAC_SHIFT;
        endcase
    end

    assign w_div_start = (r_st == ST_ROW && r_k == 4'd10 && r_s2 != '0)
                      || (r_st == ST_DIVX && w_div_done);
    assign w_div_num   = (r_st == ST_ROW) ? r_s0 : r_s1;

    hit_divider #(.W(SW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_s2),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_dx  = $signed({3'b0, r_tx}) - (SAT_SHIFT+3)'(r_px);
    assign w_dy  = $signed({3'b0, r_ty}) - (SAT_SHIFT+3)'(w_quot);
    assign w_err = (2*SAT_SHIFT+8)'(w_dx * w_dx) + (2*SAT_SHIFT+8)'(w_dy * w_dy);

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE: if (w_in_acc && s_axis_tuser == CMD_TEST)
                n_st = (w_n == '0) ? ST_DONE : ST_ROW;
            ST_ROW:  if (r_k == 4'd10) n_st = (r_s2 == '0) ? ST_NEXT : ST_DIVX;
            ST_DIVX: if (w_div_done) n_st = ST_DIVY;
            ST_DIVY: if (w_div_done) n_st = ST_NEXT;
            ST_ERR:  n_st = ST_NEXT;
            ST_NEXT: n_st = (r_m + 1'b1 >= w_n) ? ST_DONE : ST_ROW;
            ST_DONE: if (w_out_free) n_st = ST_OUT;
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && s_axis_tuser == CMD_LOAD && int'(s_axis_tdata[5:0]) < DEPTH)
            r_mem[AW'(s_axis_tdata[5:0])] <= s_axis_tdata[XB-1:CB];
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_thr    <= THR_WIDTH'(80);
            r_num    <= NUM_WIDTH'(4);
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_THRESHOLD) r_thr <= i_cfg_data;
                else if (i_cfg_index == CFG_MODELS) r_num <= i_cfg_data[NUM_WIDTH-1:0];
            end
            if (r_st == ST_OUT) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                r_rx <= s_axis_tdata[XB+COORD_WIDTH-1:XB];
                r_ry <= s_axis_tdata[XB+2*COORD_WIDTH-1:XB+COORD_WIDTH];
                r_tx <= s_axis_tdata[XB+3*COORD_WIDTH-1:XB+2*COORD_WIDTH];
                r_ty <= s_axis_tdata[XB+4*COORD_WIDTH-1:XB+3*COORD_WIDTH];
                r_m <= '0; r_k <= '0; r_addr <= '0;
                r_keep <= 1'b0; r_deg <= 1'b0; r_first <= '0; r_hits <= '0;
            end
            ST_ROW: begin
                // Read data is registered from the address of the step before; steps 1..9 accumulate.
                r_k <= r_k + 4'd1;
                if (r_k < 4'd9) r_addr <= r_addr + 1'b1;
                unique case (w_col)
                    2'd0: r_acc <= w_term;
                    2'd1: r_acc <= r_acc + w_term;
                    2'd2: begin
                        unique case (w_row)
                            2'd0:    r_s0 <= r_acc + w_term;
                            2'd1:    r_s1 <= r_acc + w_term;
                            default: r_s2 <= r_acc + w_term;
                        endcase
                    end
                    default: ;
                endcase
                if (r_k == 4'd10 && r_s2 == '0) r_deg <= 1'b1;
            end
            ST_DIVX: if (w_div_done) r_px <= w_quot;
            ST_DIVY: if (w_div_done &&
                         w_err < (2*SAT_SHIFT+8)'(r_thr * r_thr)) begin
                if (!r_keep) r_first <= 2'(r_m);
                r_keep <= 1'b1;
                r_hits[MW'(r_m)] <= 1'b1;
            end
            ST_NEXT: begin
                r_m <= r_m + 1'b1;
                r_k <= '0;
            end
            ST_DONE: if (w_out_free) begin
                r_res.keep        <= r_keep;
                r_res.first_model <= r_first;
                r_res.model_hits  <= 4'(r_hits);
                r_res.degenerate  <= r_deg;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_res.degenerate, r_res.model_hits,
                            r_res.first_model, r_res.keep};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled verdict changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_DONE && w_out_free |=> r_st == ST_OUT)
        else $error("done not followed by output");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_ROW |-> r_m < (MW+1)'(MAX_MODELS))
        else $error("model index out of range");
endmodule
